// ===== rtl/pds_pkg.sv =====
// Shared types, widths and constants for the PLL divider search unit.
// Used by pds_div and pll_divider_search_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  // Field and register widths
  localparam int unsigned TARGET_W = 31;
  localparam int unsigned REF_W    = 27;
  localparam int unsigned VMIN_W   = 30;
  localparam int unsigned VMAX_W   = 30;
  localparam int unsigned WORD_W   = 21;

  // Internal widths
  localparam int unsigned VCO_W    = 31;          // scaled target always < 2^31
  localparam int unsigned DIVD_W   = REF_W + 1;   // twice the reference
  localparam int unsigned DIVS_W   = 8;           // q up to 129
  localparam int unsigned ACC_W    = 36;          // 2*ref*p < 2^36
  localparam int unsigned P_W      = 8;
  localparam int unsigned Q_W      = 8;
  localparam int unsigned M_W      = 3;
  localparam int unsigned BAND_W   = 4;
  localparam int unsigned LIM_W    = 27;
  localparam int unsigned DCNT_W   = $clog2(DIVD_W);

  // Search ranges
  localparam int unsigned P_STEPS    = 128;
  localparam int unsigned Q_STEPS    = 128;
  localparam int unsigned BAND_COUNT = 13;
  localparam int unsigned P_FIRST    = 3;
  localparam int unsigned Q_FIRST    = 2;
  localparam int unsigned P_LAST     = P_FIRST + P_STEPS - 1;
  localparam int unsigned Q_LAST     = Q_FIRST + Q_STEPS - 1;
  localparam int unsigned M_LIMIT    = 7;

  localparam logic [ACC_W-1:0] ERR_INIT = ACC_W'(64'h7FFF_FFFF);

  // Register reset values
  localparam logic [REF_W-1:0]  REF_RESET  = REF_W'(14318180);
  localparam logic [VMIN_W-1:0] VMIN_RESET = VMIN_W'(50000000);
  localparam logic [VMAX_W-1:0] VMAX_RESET = VMAX_W'(120000000);

  // Register map indexes
  localparam int unsigned IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_VCO_MAX   = 2'd2;

  // Result of one divider pass
  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } pds_div_res_t;

  // VCO band thresholds; entries past the defined ones read as the top value
  function automatic logic [LIM_W-1:0] band_limit(input logic [BAND_W-1:0] idx);
    logic [LIM_W-1:0] lim;
    case (idx)
      4'd0:    lim = LIM_W'(51000000);
      4'd1:    lim = LIM_W'(53200000);
      4'd2:    lim = LIM_W'(58500000);
      4'd3:    lim = LIM_W'(60700000);
      4'd4:    lim = LIM_W'(64400000);
      4'd5:    lim = LIM_W'(66800000);
      4'd6:    lim = LIM_W'(73500000);
      4'd7:    lim = LIM_W'(75600000);
      4'd8:    lim = LIM_W'(80900000);
      4'd9:    lim = LIM_W'(83200000);
      4'd10:   lim = LIM_W'(91500000);
      4'd11:   lim = LIM_W'(100000000);
      default: lim = LIM_W'(120000000);
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pds_div.sv =====
// Restoring serial divider: twice the reference divided by q, one bit a cycle.
// Depends on pds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pds_div
  import pds_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [DIVS_W-1:0] divisor_i,
  output pds_div_res_t           res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0] quot_q, quot_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;

  logic [DIVS_W:0]   shifted;
  logic              fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quot_q[DIVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? DIVS_W'(shifted - {1'b0, dvs_q}) : shifted[DIVS_W-1:0];
      quot_d = {quot_q[DIVD_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/pll_divider_search_unit.sv =====
// PLL divider search unit: top level with register port, sequencer and search.
// Depends on pds_pkg and pds_div.
//
// One request takes a target frequency and yields one packed control word
// band<<17 | (p-3)<<10 | m<<7 | (q-2), or word 0 with valid_res clear when the
// target is zero, needs more than seven doublings, or scales above vco_max.
// A valid request scales the target by doubling, walks the band table, then
// for each of the 128 values of q runs a serial division of twice the
// reference by q followed by accumulate steps that walk p from 0 to 130, and
// finally drains and hands over the result. Invalid requests skip the search.
// in_ready_o is high only while the sequencer is idle; a finished result sits in
// an output register, so the next request may be taken while it waits. Registers
// must be written only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module pll_divider_search_unit
  import pds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // APB register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // Request channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [TARGET_W-1:0] target_hz_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [WORD_W-1:0]   pll_word_o,
  output logic                     valid_res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_BAND,
    ST_DIV,
    ST_STEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Configuration registers
  logic [REF_W-1:0]  ref_q;
  logic [VMIN_W-1:0] vmin_q;
  logic [VMAX_W-1:0] vmax_q;
  logic [IDX_W-1:0]  reg_idx;
  logic              cfg_wr;

  // Sequencer and datapath state
  state_e            state_q, state_d;
  logic [VCO_W-1:0]  vco_q, vco_d;
  logic [M_W-1:0]    m_q, m_d;
  logic [BAND_W-1:0] band_q, band_d;
  logic [P_W-1:0]    p_q, p_d;
  logic [Q_W-1:0]    q_q, q_d;
  logic [DIVD_W-1:0] a_q, a_d;
  logic [DIVS_W-1:0] b_q, b_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DIVS_W-1:0] racc_q, racc_d;
  logic              ok_q, ok_d;
  logic              div_start_q, div_start_d;

  // Evaluation stage
  logic              ev_q, ev_d;
  logic [ACC_W-1:0]  err_q, err_d;
  logic [P_W-1:0]    ev_p_q, ev_p_d;
  logic [Q_W-1:0]    ev_qv_q, ev_qv_d;

  // Best pair so far
  logic [ACC_W-1:0]  best_err_q, best_err_d;
  logic [P_W-1:0]    best_p_q, best_p_d;
  logic [Q_W-1:0]    best_qv_q, best_qv_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              res_ok_q, res_ok_d;

  pds_div_res_t      div_res;
  logic [DIVD_W-1:0] twice_ref;
  logic [DIVS_W:0]   rsum;
  logic              wrap;
  logic [ACC_W-1:0]  vco_ext;
  logic              better;
  logic [WORD_W-1:0] packed_word;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx)
      REG_REFERENCE: prdata = 32'(ref_q);
      REG_VCO_MIN:   prdata = 32'(vmin_q);
      REG_VCO_MAX:   prdata = 32'(vmax_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= REF_RESET;
      vmin_q <= VMIN_RESET;
      vmax_q <= VMAX_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_REFERENCE: ref_q  <= pwdata[REF_W-1:0];
        REG_VCO_MIN:   vmin_q <= pwdata[VMIN_W-1:0];
        REG_VCO_MAX:   vmax_q <= pwdata[VMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared divider: floor(2*ref/q) and its remainder, once per q
  assign twice_ref = {ref_q, 1'b0};

  pds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (twice_ref),
    .divisor_i  (q_q),
    .res_o      (div_res)
  );

  // Accumulate step: 2*ref*p/q tracked as quotient and remainder
  assign rsum    = {1'b0, racc_q} + {1'b0, b_q};
  assign wrap    = rsum >= {1'b0, q_q};
  assign vco_ext = ACC_W'(vco_q);

  // Earlier pair in p-major order wins a tie
  assign better = ev_q &&
                  ((err_q < best_err_q) || ((err_q == best_err_q) && (ev_p_q < best_p_q)));

  assign packed_word = {band_q,
                        7'(best_p_q - P_W'(P_FIRST)),
                        m_q,
                        7'(best_qv_q - Q_W'(Q_FIRST))};

  always_comb begin
    state_d     = state_q;
    vco_d       = vco_q;
    m_d         = m_q;
    band_d      = band_q;
    p_d         = p_q;
    q_d         = q_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    racc_d      = racc_q;
    ok_d        = ok_q;
    div_start_d = 1'b0;
    ev_d        = 1'b0;
    err_d       = err_q;
    ev_p_d      = ev_p_q;
    ev_qv_d     = ev_qv_q;
    best_err_d  = best_err_q;
    best_p_d    = best_p_q;
    best_qv_d   = best_qv_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    word_d      = word_q;
    res_ok_d    = res_ok_q;

    // Keep the best pair
    if (better) begin
      best_err_d = err_q;
      best_p_d   = ev_p_q;
      best_qv_d  = ev_qv_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vco_d = VCO_W'(target_hz_i);
          m_d   = '0;
          ok_d  = 1'b0;
          if (target_hz_i == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCALE;
          end
        end
      end

      // Double until the VCO minimum is reached; give up past seven doublings or above vco_max
      ST_SCALE: begin
        if (vco_q < VCO_W'(vmin_q)) begin
          if (m_q == M_W'(M_LIMIT)) begin
            state_d = ST_FINISH;
          end else begin
            vco_d = {vco_q[VCO_W-2:0], 1'b0};
            m_d   = m_q + 1'b1;
          end
        end else if (vco_q > VCO_W'(vmax_q)) begin
          state_d = ST_FINISH;
        end else begin
          band_d  = '0;
          state_d = ST_BAND;
        end
      end

      // Walk the band table one threshold a cycle
      ST_BAND: begin
        if ((band_q < BAND_W'(BAND_COUNT - 1)) && (vco_q > VCO_W'(band_limit(band_q)))) begin
          band_d = band_q + 1'b1;
        end else begin
          q_d         = Q_W'(Q_FIRST);
          best_err_d  = ERR_INIT;
          best_p_d    = P_W'(P_FIRST);
          best_qv_d   = Q_W'(Q_FIRST);
          div_start_d = 1'b1;
          state_d     = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          a_d     = div_res.quot;
          b_d     = div_res.rem;
          acc_d   = '0;
          racc_d  = '0;
          p_d     = '0;
          state_d = ST_STEP;
        end
      end

      // One p a cycle; the first few steps only build up the product
      ST_STEP: begin
        if (p_q >= P_W'(P_FIRST)) begin
          ev_d    = 1'b1;
          err_d   = (vco_ext >= acc_q) ? vco_ext - acc_q : acc_q - vco_ext;
          ev_p_d  = p_q;
          ev_qv_d = q_q;
        end
        acc_d  = acc_q + ACC_W'(a_q) + ACC_W'(wrap);
        racc_d = wrap ? DIVS_W'(rsum - {1'b0, q_q}) : rsum[DIVS_W-1:0];
        p_d    = p_q + 1'b1;
        if (p_q == P_W'(P_LAST)) begin
          if (q_q == Q_W'(Q_LAST)) begin
            state_d = ST_DRAIN;
          end else begin
            q_d         = q_q + 1'b1;
            div_start_d = 1'b1;
            state_d     = ST_DIV;
          end
        end
      end

      // Last evaluation lands in the best registers here
      ST_DRAIN: begin
        ok_d    = 1'b1;
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          word_d      = ok_q ? packed_word : '0;
          res_ok_d    = ok_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      ev_q        <= 1'b0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      res_ok_q    <= 1'b0;
      word_q      <= '0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      res_ok_q    <= res_ok_d;
      word_q      <= word_d;
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    vco_q      <= vco_d;
    m_q        <= m_d;
    band_q     <= band_d;
    p_q        <= p_d;
    q_q        <= q_d;
    a_q        <= a_d;
    b_q        <= b_d;
    acc_q      <= acc_d;
    racc_q     <= racc_d;
    err_q      <= err_d;
    ev_p_q     <= ev_p_d;
    ev_qv_q    <= ev_qv_d;
    best_err_q <= best_err_d;
    best_p_q   <= best_p_d;
    best_qv_q  <= best_qv_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pll_word_o  = word_q;
  assign valid_res_o = res_ok_q;

`ifndef SYNTHESIS
  // An invalid result carries a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> pll_word_o == '0)
    else $error("invalid result with non-zero control word");

  // Evaluations only come out of the accumulate steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q |-> $past(state_q) == ST_STEP)
    else $error("evaluation outside the p walk");

  // The divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider result with nobody waiting");

  // A successful search leaves a pair inside the search ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && ok_q |->
      best_p_q >= P_W'(P_FIRST) && best_p_q <= P_W'(P_LAST) &&
      best_qv_q >= Q_W'(Q_FIRST) && best_qv_q <= Q_W'(Q_LAST))
    else $error("best pair out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/pds_checker.sv =====
// Result checker for the PLL divider search unit: watches the register port and
// the request and result channels, predicts each control word and compares it on arrival.
// Depends on pds_pkg for widths, search ranges, reset values and register indexes.
`timescale 1ns / 1ps

module pds_checker
  import pds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic [TARGET_W-1:0] target_hz_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [WORD_W-1:0]   pll_word_o,
  input  logic                valid_res_o,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  valid_results_o
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ok;
  } search_result_t;

  // VCO band thresholds; the top entries repeat the last defined one
  longint unsigned band_top [16] = '{
    64'd51000000, 64'd53200000, 64'd58500000, 64'd60700000,
    64'd64400000, 64'd66800000, 64'd73500000, 64'd75600000,
    64'd80900000, 64'd83200000, 64'd91500000, 64'd100000000,
    64'd120000000, 64'd120000000, 64'd120000000, 64'd120000000
  };

  // Local copy of the register file
  logic [REF_W-1:0]  ref_hz;
  logic [VMIN_W-1:0] vmin_hz;
  logic [VMAX_W-1:0] vmax_hz;

  search_result_t expected_words [$];

  // Scale, pick the band, then exhaustive p/q search; first best pair wins
  function automatic search_result_t search_pll_word(input logic [TARGET_W-1:0] target);
    longint unsigned vco, twice_ref, synth, err, best_err;
    longint unsigned p, q, best_p, best_q, m, band;
    search_result_t res;
    res.word = '0;
    res.ok   = 1'b0;
    vco      = target;
    m        = 0;
    if (vco == 0) return res;
    while (vco < vmin_hz) begin
      if (m >= M_LIMIT) return res;
      vco = vco << 1;
      m++;
    end
    if (vco > vmax_hz) return res;
    band = 0;
    while (band < BAND_COUNT - 1 && vco > band_top[band]) band++;
    twice_ref = longint'(ref_hz) << 1;
    best_err  = 64'h7FFF_FFFF;
    best_p    = P_FIRST;
    best_q    = Q_FIRST;
    for (p = P_FIRST; p <= P_LAST; p++) begin
      for (q = Q_FIRST; q <= Q_LAST; q++) begin
        synth = (twice_ref * p) / q;
        err   = (vco >= synth) ? vco - synth : synth - vco;
        if (err < best_err) begin
          best_err = err;
          best_p   = p;
          best_q   = q;
        end
      end
    end
    res.word = WORD_W'((band << 17) | ((best_p - P_FIRST) << 10) | (m << 7)
                       | (best_q - Q_FIRST));
    res.ok   = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Register and channel monitor: results are compared before new requests are queued
  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t want;
    if (!rst_ni) begin
      ref_hz           = REF_RESET;
      vmin_hz          = VMIN_RESET;
      vmax_hz          = VMAX_RESET;
      mismatch_count_o = 0;
      results_o        = 0;
      valid_results_o  = 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_REFERENCE: ref_hz  = pwdata[REF_W-1:0];
          REG_VCO_MIN:   vmin_hz = pwdata[VMIN_W-1:0];
          REG_VCO_MAX:   vmax_hz = pwdata[VMAX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        results_o++;
        if (valid_res_o) valid_results_o++;
        if (expected_words.size() == 0) begin
          report_mismatch("result with no request waiting", pll_word_o, 0);
        end else begin
          want = expected_words.pop_front();
          if (pll_word_o !== want.word)
            report_mismatch("pll_word", pll_word_o, want.word);
          if (valid_res_o !== want.ok)
            report_mismatch("valid_res", valid_res_o, want.ok);
        end
      end
      if (in_valid_i && in_ready_o)
        expected_words.push_back(search_pll_word(target_hz_i));
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the PLL divider search testbench: clock, reset, register writes,
// request stimulus, result-side back-pressure, watchdog and verdict.
// Depends on pds_pkg, pll_divider_search_unit and pds_checker.
`timescale 1ns / 1ps

module testbench;
  import pds_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 64;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [3:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [TARGET_W-1:0] target_hz_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WORD_W-1:0]   pll_word_o;
  logic                valid_res_o;

  int mismatch_count, pending, results, valid_results;
  int requests_sent  = 0;
  int settings_used  = 1;
  int idle_cycles    = 0;

  // Shared flags between stimulus and the result-side process
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;
  bit hold_done   = 1'b0;

  // Mirror of what was written, for shaping targets
  longint unsigned cfg_ref  = REF_RESET;
  longint unsigned cfg_vmin = VMIN_RESET;
  longint unsigned cfg_vmax = VMAX_RESET;

  always #5 clk_i = ~clk_i;

  pll_divider_search_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_hz_i (target_hz_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pll_word_o  (pll_word_o),
    .valid_res_o (valid_res_o)
  );

  pds_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_hz_i      (target_hz_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pll_word_o       (pll_word_o),
    .valid_res_o      (valid_res_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .results_o        (results),
    .valid_results_o  (valid_results)
  );

  // Watchdog: cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Register write: setup cycle, then access until pready
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_REFERENCE: cfg_ref  = value;
      REG_VCO_MIN:   cfg_vmin = value;
      REG_VCO_MAX:   cfg_vmax = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input longint unsigned ref_v, input longint unsigned vmin_v,
                            input longint unsigned vmax_v);
    write_reg(REG_REFERENCE, 32'(ref_v));
    write_reg(REG_VCO_MIN, 32'(vmin_v));
    write_reg(REG_VCO_MAX, 32'(vmax_v));
    settings_used++;
  endtask

  // Offer one request and hold it until taken
  task automatic send_target(input logic [TARGET_W-1:0] t);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    target_hz_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  // Let every outstanding request come back before touching the registers
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // Targets reachable under the current setting in 30 of 100 picks, plus noise
  function automatic logic [TARGET_W-1:0] random_target();
    int unsigned pick, m;
    longint unsigned vco;
    logic [TARGET_W-1:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 30 && cfg_vmin <= cfg_vmax) begin
      vco = $urandom_range(cfg_vmin, cfg_vmax);
      m   = $urandom_range(0, M_LIMIT);
      t   = TARGET_W'(vco >> m);
      if (t == 0) t = TARGET_W'(1);
    end else if (pick < 50) begin
      t = TARGET_W'($urandom_range(0, 20000));
    end else if (pick < 55) begin
      t = '0;
    end else begin
      t = TARGET_W'($urandom());
    end
    return t;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_target(random_target());
    drain();
  endtask

  initial begin
    longint unsigned vmin_r, vmax_r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: zero, too many doublings, limits, band edges
    send_target(31'd0);
    send_target(31'd1);
    send_target(31'd390624);
    send_target(31'd390625);
    send_target(31'd50000000);
    send_target(31'd49999999);
    send_target(31'd51000001);
    send_target(31'd100000001);
    send_target(31'd120000000);
    send_target(31'd120000001);
    send_target(31'h7FFF_FFFF);
    drain();

    // Long hold-off on results while cheap rejected requests keep coming
    hold_req = 1'b1;
    wait (hold_active);
    send_target(31'd0);
    send_target(31'h7FFF_FFFF);
    send_target(31'h5555_5555);
    send_target(31'h2AAA_AAAA);
    send_target(31'd2);
    send_target(31'h4000_0000);
    send_target(31'd120000001);
    send_target(31'd3);
    drain();

    // Extremes: widest VCO window, fastest reference; unmapped write ignored
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    set_config(100000000, 1000000, 1000000000);
    send_target(31'd1000000);
    send_target(31'd999999);
    send_target(31'd1000000000);
    send_target(31'd1000000001);
    send_target(31'd7813);
    send_target(31'd7812);
    drain();

    // Inverted window with slowest reference: nothing is reachable
    set_config(1000000, 1000000000, 1000000);
    random_phase(10);

    // Random settings; the last one runs without idling
    for (int phase = 0; phase < 3; phase++) begin
      vmin_r = $urandom_range(1000000, 1000000000);
      vmax_r = ($urandom_range(0, 5) == 0) ? $urandom_range(1000000, 1000000000)
                                           : $urandom_range(vmin_r, 1000000000);
      set_config($urandom_range(1000000, 100000000), vmin_r, vmax_r);
      if (phase == 2) quiet = 1'b1;
      random_phase(22);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Searched %0d targets under %0d register settings: %0d words found, %0d rejected",
             requests_sent, settings_used, valid_results, results - valid_results);
    $display("Included one %0d-cycle result hold-off with the request side kept busy",
             HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pds_pkg.sv
rtl/pds_div.sv
rtl/pll_divider_search_unit.sv
verif/pds_checker.sv
verif/testbench.sv
